>>> design/assert_macros.svh
// Assertion helpers for the multi-channel byte FIFO.
// Both macros go away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MCBF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define MCBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define MCBF_ASSERT(lbl, clk, rstn, prop, msg)

`define MCBF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> design/mcbf_pkg.sv
`timescale 1ns / 1ps

package mcbf_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int QUEUE_DEPTH  = 256;
  localparam int NUM_QUEUES   = NUM_CHANNELS * 2;

  localparam int OP_W   = 2;
  localparam int CHAN_W = 3;
  localparam int DATA_W = 8;
  localparam int ST_W   = 2;
  localparam int FS_W   = 9;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_W       = $clog2(NUM_QUEUES);
  localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W     = $clog2(2 * QUEUE_DEPTH - 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_FULL        = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/mcbf_channels.sv
`timescale 1ns / 1ps

interface mcbf_req_if;
  logic                       valid;
  logic                       ready;
  logic [mcbf_pkg::OP_W-1:0]   opcode;
  logic [mcbf_pkg::CHAN_W-1:0] channel;
  logic                       direction;
  logic [mcbf_pkg::DATA_W-1:0] data_in;

  modport source (output valid, opcode, channel, direction, data_in, input ready);
  modport sink   (input valid, opcode, channel, direction, data_in, output ready);
endinterface

interface mcbf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mcbf_pkg::ST_W-1:0]          status;
  logic [mcbf_pkg::DATA_W-1:0]        data_out;
  logic signed [mcbf_pkg::FS_W-1:0]   free_space;

  modport source (output valid, status, data_out, free_space, input ready);
  modport sink   (input valid, status, data_out, free_space, output ready);
endinterface

>>> design/mcbf_ctrl.sv
`timescale 1ns / 1ps

module mcbf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcbf_pkg::dp_stat_t    stat_i,
  output mcbf_pkg::ctrl_cmd_t   cmd_o
);
  import mcbf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (stat_i.in_valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        // Hold the finished result until the output register can take it.
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.in_ready = (state_q == S_IDLE);
  assign cmd_o.capture  = (state_q == S_IDLE) && stat_i.in_valid;
  assign cmd_o.exec     = (state_q == S_EXEC);
  assign cmd_o.load     = (state_q == S_LOAD) && stat_i.out_free;

endmodule

>>> design/mcbf_datapath.sv
`timescale 1ns / 1ps

module mcbf_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcbf_pkg::ctrl_cmd_t   cmd_i,
  output mcbf_pkg::dp_stat_t    stat_o,
  mcbf_req_if.sink              req_i,
  mcbf_rsp_if.source            rsp_o
);
  import mcbf_pkg::*;

  // Captured request.
  logic [OP_W-1:0]   op_q;
  logic [CHAN_W-1:0] chan_q;
  logic              dir_q;
  logic [DATA_W-1:0] data_q;

  // Queue state.
  logic [PTR_W-1:0] wr_ptr_q [NUM_QUEUES];
  logic [PTR_W-1:0] rd_ptr_q [NUM_QUEUES];
  logic [CNT_W-1:0] cnt_q    [NUM_CHANNELS];

  // Byte store, no reset; a pop only reads slots an earlier push wrote.
  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Results of the execute step.
  logic [ST_W-1:0]        res_status_q;
  logic                   res_pop_ok_q;
  logic signed [FS_W-1:0] res_fs_q;

  // Output register.
  logic                   out_valid_q;
  logic [ST_W-1:0]        out_status_q;
  logic [DATA_W-1:0]      out_data_q;
  logic signed [FS_W-1:0] out_fs_q;

  logic [Q_W-1:0]      q_idx;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                bad;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    rp;
  logic [PTR_W-1:0]    wp_next;
  logic [PTR_W-1:0]    rp_next;
  logic                push_ok;
  logic                pop_ok;
  logic [ST_W-1:0]     status;
  logic signed [FS_W-1:0] fs;
  logic [MEM_AW-1:0]   addr;

  assign q_idx   = Q_W'({chan_q, dir_q});
  assign ch_idx  = CH_IDX_W'(chan_q);
  assign bad     = {1'b0, chan_q} >= (CHAN_W + 1)'(NUM_CHANNELS);
  assign wp      = wr_ptr_q[q_idx];
  assign rp      = rd_ptr_q[q_idx];
  assign wp_next = (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_next = (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign fs      = FS_W'(QUEUE_DEPTH - 1) - FS_W'(cnt_q[ch_idx]);
  assign addr    = MEM_AW'(int'(q_idx) * QUEUE_DEPTH) + MEM_AW'(op_q == OP_PUSH ? wp : rp);

  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    status  = ST_OK;
    case (op_e'(op_q))
      OP_PUSH: begin
        if (bad) begin
          status = ST_BAD_CHANNEL;
        end else if (wp_next == rp) begin
          status = ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (bad) begin
          status = ST_BAD_CHANNEL;
        end else if (wp == rp) begin
          status = ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
        end
      end
      OP_QUERY: begin
        if (bad) begin
          status = ST_BAD_CHANNEL;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= req_i.opcode;
      chan_q <= req_i.channel;
      dir_q  <= req_i.direction;
      data_q <= req_i.data_in;
    end
    if (cmd_i.exec) begin
      res_status_q <= status;
      res_pop_ok_q <= pop_ok;
      res_fs_q     <= (op_q == OP_QUERY && !bad) ? fs : '0;
    end
    if (cmd_i.load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_pop_ok_q ? rdata_q : '0;
      out_fs_q     <= res_fs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem_q[addr] <= data_q;
    end
    if (cmd_i.exec && pop_ok) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wr_ptr_q[i] <= '0;
        rd_ptr_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      if (push_ok) begin
        wr_ptr_q[q_idx] <= wp_next;
        cnt_q[ch_idx]   <= cnt_q[ch_idx] + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q[q_idx] <= rp_next;
        cnt_q[ch_idx]   <= cnt_q[ch_idx] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.in_valid = req_i.valid;
  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready      = cmd_i.in_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.free_space = out_fs_q;

endmodule

>>> design/multi_channel_byte_fifo_top.sv
// Six serial channels, each with two byte queues of 255 bytes, in one
// single-port byte store. A request (push, pop or free-space query) is
// taken when the block is idle; it then passes an execute step and a load
// step before its response appears, and the block takes no new request
// until that response has been loaded into the output register. The
// steps come from the single store port: the execute step looks up the
// queue pointers and reads or writes the store, the load step moves the
// registered store data into the output register. A response that waits
// on the output holds the block in its last step. Free space is reported
// per channel, shared by both directions, and may be negative.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_channel_byte_fifo_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcbf_req_if.sink    req_i,
  mcbf_rsp_if.source  rsp_o
);
  import mcbf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mcbf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mcbf_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  `MCBF_ASSERT_NEXT(a_one_request, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request taken while another is in flight")
  `MCBF_ASSERT(a_one_step, clk_i, rst_ni, $onehot0({cmd.capture, cmd.exec, cmd.load}), "controller issued overlapping steps")
  `MCBF_ASSERT(a_load_free, clk_i, rst_ni, cmd.load |-> stat.out_free, "result loaded over an unread response")
  `MCBF_ASSERT(a_bad_zero, clk_i, rst_ni, (rsp_o.valid && rsp_o.status == ST_BAD_CHANNEL) |-> (rsp_o.data_out == '0 && rsp_o.free_space == '0), "bad channel response carries data")

endmodule
